FILE: rtl/pcm16f32_pkg.sv
// Package for the PCM16 / float32 sample converter.
// Holds the direction codes, IEEE single constants and a leading-one helper.
// No dependencies.
package pcm16f32_pkg;

  localparam logic DIR_TO_FLOAT = 1'b0;
  localparam logic DIR_TO_INT   = 1'b1;

  localparam logic [31:0] FLT_ONE_MAG  = 32'h3F80_0000;
  localparam logic [7:0]  EXP_ONE      = 8'd127;
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
  // Smallest biased exponent whose product with 32767 can reach 1.0.
  localparam logic [7:0]  EXP_MIN_INT  = 8'd112;
  localparam logic [7:0]  EXP_BIAS_SH  = 8'd150;

  localparam logic [15:0] INT_MAX     = 16'h7FFF;
  localparam logic [15:0] INT_MIN     = 16'h8000;
  localparam logic [15:0] INT_NEG_MAX = 16'h8001;
  localparam logic [15:0] MAG_FULL    = 16'h7FFF;
  localparam logic [15:0] MAG_OVER    = 16'h8000;

  // Position of the highest set bit of a 15-bit value (0 when none).
  function automatic logic [3:0] lead_one(input logic [14:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/pcm16_float32_converter_top.sv
// Top level of the PCM16 / float32 sample converter.
// Depends on pcm16f32_pkg for constants and the leading-one helper.
//
// Converts one sample per item in the direction held in the cfg register:
// 0 turns a signed 16-bit sample into the IEEE single nearest to
// sample/32767, 1 turns an IEEE single into int16 by f*32767 (rounded to
// single, then truncated toward zero), saturating at 1.0 and below -1.0
// with the clipped flag set; NaN gives 0. One item is accepted per cycle
// unless both stages are full and held by back-pressure. Each item passes
// through an input register, one pass of conversion logic, and a result
// register. Both stages hold under back-pressure. Write cfg only while
// no item is in flight.
module pcm16_float32_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_bits
  output logic        out_tuser   // [0] clipped
);

  logic        dir_r;
  logic        s1_valid_r;
  logic [31:0] s1_data_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_clip_r;

  logic s1_en;
  logic s2_en;

  assign cfg_ready  = 1'b1;
  assign s2_en      = !out_valid_r || out_tready;
  assign s1_en      = !s1_valid_r || s2_en;
  assign in_tready  = s1_en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // int16 to float
  logic        fs_sign;
  logic [15:0] fs_mag;
  logic [14:0] fs_a;
  logic [3:0]  fs_p;
  logic [44:0] fs_rep;
  logic [44:0] fs_sh;
  logic [30:0] fs_em;
  logic [31:0] flt_res;

  always_comb begin
    fs_sign = s1_data_r[15];
    fs_mag  = fs_sign ? (~s1_data_r[15:0] + 16'd1) : s1_data_r[15:0];
    fs_a    = fs_mag[14:0];
    fs_p    = pcm16f32_pkg::lead_one(fs_a);
    // a/32767 in binary is the 15-bit magnitude repeated forever, so the
    // sticky part is never zero and the guard bit alone decides rounding.
    fs_rep  = {fs_a, fs_a, fs_a};
    fs_sh   = fs_rep << (4'd14 - fs_p);
    fs_em   = {pcm16f32_pkg::EXP_MIN_INT + {4'd0, fs_p}, fs_sh[43:21]}
              + {30'd0, fs_sh[20]};
    if (fs_mag == 16'd0) begin
      flt_res = 32'd0;
    end else if (fs_mag == pcm16f32_pkg::MAG_FULL) begin
      flt_res = {fs_sign, pcm16f32_pkg::FLT_ONE_MAG[30:0]};
    end else if (fs_mag == pcm16f32_pkg::MAG_OVER) begin
      // -32768/32767 = -(1 + 2^-15 + ...), rounds down to 1 + 2^-15.
      flt_res = {1'b1, pcm16f32_pkg::EXP_ONE, 23'h000100};
    end else begin
      flt_res = {fs_sign, fs_em};
    end
  end

  // float to int16
  logic        fi_sign;
  logic [7:0]  fi_exp;
  logic [23:0] fi_m;
  logic [38:0] fi_p;
  logic        fi_hi;
  logic [23:0] fi_keep;
  logic        fi_g;
  logic        fi_st;
  logic [24:0] fi_r;
  logic [7:0]  fi_shamt;
  logic [24:0] fi_shr;
  logic [15:0] fi_mag;
  logic [15:0] int_res;
  logic        int_clip;

  always_comb begin
    fi_sign  = s1_data_r[31];
    fi_exp   = s1_data_r[30:23];
    fi_m     = {1'b1, s1_data_r[22:0]};
    fi_p     = {fi_m, 15'd0} - {15'd0, fi_m};
    fi_hi    = fi_p[38];
    fi_keep  = fi_hi ? fi_p[38:15] : fi_p[37:14];
    fi_g     = fi_hi ? fi_p[14] : fi_p[13];
    fi_st    = fi_hi ? (|fi_p[13:0]) : (|fi_p[12:0]);
    fi_r     = {1'b0, fi_keep} + {24'd0, fi_g && (fi_st || fi_keep[0])};
    fi_shamt = pcm16f32_pkg::EXP_BIAS_SH - fi_exp - (fi_hi ? 8'd15 : 8'd14);
    fi_shr   = fi_r >> fi_shamt[4:0];
    fi_mag   = fi_shr[15:0];
    int_clip = 1'b0;
    if (fi_exp == pcm16f32_pkg::EXP_ALL_ONES && s1_data_r[22:0] != 23'd0) begin
      int_res = 16'd0;
    end else if (!fi_sign && fi_exp >= pcm16f32_pkg::EXP_ONE) begin
      int_res  = pcm16f32_pkg::INT_MAX;
      int_clip = 1'b1;
    end else if (fi_sign && s1_data_r[30:0] > pcm16f32_pkg::FLT_ONE_MAG[30:0]) begin
      int_res  = pcm16f32_pkg::INT_MIN;
      int_clip = 1'b1;
    end else if (fi_sign && s1_data_r[30:0] == pcm16f32_pkg::FLT_ONE_MAG[30:0]) begin
      int_res = pcm16f32_pkg::INT_NEG_MAX;
    end else if (fi_exp < pcm16f32_pkg::EXP_MIN_INT) begin
      int_res = 16'd0;
    end else begin
      int_res = fi_sign ? (~fi_mag + 16'd1) : fi_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= pcm16f32_pkg::DIR_TO_FLOAT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dir_r <= cfg_data;
      end
      if (s1_en) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
    if (s2_en && s1_valid_r) begin
      if (dir_r == pcm16f32_pkg::DIR_TO_INT) begin
        out_data_r <= {16'd0, int_res};
        out_clip_r <= int_clip;
      end else begin
        out_data_r <= flt_res;
        out_clip_r <= 1'b0;
      end
    end
  end

endmodule
